// ----- src/mi3_pkg.sv -----
// Shared types and constants for the 3x3 matrix inverse unit.
// No dependencies; every other file imports this package.
package mi3_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FRONT_STAGES  = 5;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] a_r0c0;
        logic signed [DATA_WIDTH-1:0] a_r0c1;
        logic signed [DATA_WIDTH-1:0] a_r0c2;
        logic signed [DATA_WIDTH-1:0] a_r1c0;
        logic signed [DATA_WIDTH-1:0] a_r1c1;
        logic signed [DATA_WIDTH-1:0] a_r1c2;
        logic signed [DATA_WIDTH-1:0] a_r2c0;
        logic signed [DATA_WIDTH-1:0] a_r2c1;
        logic signed [DATA_WIDTH-1:0] a_r2c2;
    } mi3_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] inv_r0c0;
        logic signed [DATA_WIDTH-1:0] inv_r0c1;
        logic signed [DATA_WIDTH-1:0] inv_r0c2;
        logic signed [DATA_WIDTH-1:0] inv_r1c0;
        logic signed [DATA_WIDTH-1:0] inv_r1c1;
        logic signed [DATA_WIDTH-1:0] inv_r1c2;
        logic signed [DATA_WIDTH-1:0] inv_r2c0;
        logic signed [DATA_WIDTH-1:0] inv_r2c1;
        logic signed [DATA_WIDTH-1:0] inv_r2c2;
        logic                         singular;
        logic                         saturated;
    } mi3_out_t;

endpackage

// ----- src/mi3_front.sv -----
// Front pipeline: 2x2 products, adjugate terms, determinant, magnitudes.
// Depends on mi3_pkg. Five register stages, each advanced by its load bit.
module mi3_front
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic [FRONT_STAGES-1:0]             load,
    input  logic signed [DATA_WIDTH-1:0]        elem [9],
    output logic [3*DATA_WIDTH+1:0]             dmag,
    output logic                                dzero,
    output logic [2*DATA_WIDTH+2*FRAC_BITS:0]   nmag [9],
    output logic                                nneg [9]
);

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = 2*DW;
    localparam int AW   = 2*DW+1;
    localparam int DETW = 3*DW+2;
    localparam int NW   = 2*DW+2*FRAC_BITS+1;

    // element indices p,q,r,s of adjugate term p*q - r*s, row-major
    localparam int TERM [9][4] = '{
        '{4,8,5,7}, '{2,7,1,8}, '{1,5,2,4},
        '{5,6,3,8}, '{0,8,2,6}, '{2,3,0,5},
        '{3,7,4,6}, '{1,6,0,7}, '{0,4,1,3}
    };

    logic signed [PW-1:0]   p0_reg [9];
    logic signed [PW-1:0]   p1_reg [9];
    logic signed [DW-1:0]   r0a_reg [3];
    logic signed [DW-1:0]   r0b_reg [3];
    logic signed [DW-1:0]   r0c_reg [3];
    logic signed [AW-1:0]   adj2_reg [9];
    logic signed [AW-1:0]   adj3_reg [9];
    logic signed [AW-1:0]   adj4_reg [9];
    logic signed [AW-1:0]   plo_reg [3];
    logic signed [AW-1:0]   phi_reg [3];
    logic signed [DETW-1:0] det_reg;
    logic [DETW-1:0]        dmag_reg;
    logic                   dzero_reg;
    logic [NW-1:0]          nmag_reg [9];
    logic                   nneg_reg [9];

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            for (int t = 0; t < 9; t++)
            begin
                p0_reg[t] <= PW'(elem[TERM[t][0]]) * PW'(elem[TERM[t][1]]);
                p1_reg[t] <= PW'(elem[TERM[t][2]]) * PW'(elem[TERM[t][3]]);
            end
            for (int j = 0; j < 3; j++)
                r0a_reg[j] <= elem[j];
        end
        if (load[1])
        begin
            for (int t = 0; t < 9; t++)
                adj2_reg[t] <= AW'(p0_reg[t]) - AW'(p1_reg[t]);
            r0b_reg <= r0a_reg;
        end
        if (load[2])
        begin
            // split each row-0 cofactor (adjugate column 0) into an unsigned low and a signed high part
            for (int j = 0; j < 3; j++)
            begin
                plo_reg[j] <= AW'(r0b_reg[j])
                            * AW'($signed({1'b0, adj2_reg[3*j][DW-1:0]}));
                phi_reg[j] <= AW'(r0b_reg[j]) * AW'($signed(adj2_reg[3*j][AW-1:DW]));
            end
            adj3_reg <= adj2_reg;
            r0c_reg  <= r0b_reg;
        end
        if (load[3])
        begin
            det_reg <= (DETW'(phi_reg[0]) <<< DW) + DETW'(plo_reg[0])
                     + (DETW'(phi_reg[1]) <<< DW) + DETW'(plo_reg[1])
                     + (DETW'(phi_reg[2]) <<< DW) + DETW'(plo_reg[2]);
            adj4_reg <= adj3_reg;
        end
        if (load[4])
        begin
            dzero_reg <= (det_reg == '0);
            dmag_reg  <= det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
            for (int t = 0; t < 9; t++)
            begin
                nmag_reg[t] <= (adj4_reg[t][AW-1] ? NW'(AW'(-adj4_reg[t]))
                                                  : NW'(AW'(adj4_reg[t])))
                               << (2*FRAC_BITS);
                nneg_reg[t] <= adj4_reg[t][AW-1] ^ det_reg[DETW-1];
            end
        end
    end

    assign dmag  = dmag_reg;
    assign dzero = dzero_reg;
    assign nmag  = nmag_reg;
    assign nneg  = nneg_reg;

endmodule

// ----- src/mi3_lane.sv -----
// One division lane: overflow check, then one restoring quotient bit per stage.
// Depends on mi3_pkg. DATA_WIDTH+2 register stages, each advanced by its load bit.
module mi3_lane
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                               clk,
    input  logic [DATA_WIDTH+1:0]              load,
    input  logic [2*DATA_WIDTH+2*FRAC_BITS:0]  nmag,
    input  logic [3*DATA_WIDTH+1:0]            dmag,
    input  logic                               nneg,
    input  logic                               dzero,
    output logic [DATA_WIDTH:0]                quo,
    output logic                               over,
    output logic                               neg,
    output logic                               zero
);

    localparam int DW   = DATA_WIDTH;
    localparam int DETW = 3*DW+2;
    localparam int NW   = 2*DW+2*FRAC_BITS+1;
    localparam int CW   = (NW > DETW+DW+2) ? NW : DETW+DW+2;
    localparam int NS   = DW+2;

    logic [NW-1:0]   rem_reg  [NS];
    logic [DETW-1:0] d_reg    [NS];
    logic [DW:0]     q_reg    [NS];
    logic            over_reg [NS];
    logic            neg_reg  [NS];
    logic            zero_reg [NS];

    // quotient beyond DW+1 bits saturates anyway: flag it and skip those bits
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            over_reg[0] <= (CW'(nmag) >= (CW'(dmag) << (DW+1)));
            rem_reg[0]  <= nmag;
            d_reg[0]    <= dmag;
            q_reg[0]    <= '0;
            neg_reg[0]  <= nneg;
            zero_reg[0] <= dzero;
        end
    end

    for (genvar s = 0; s < NS-1; s++)
    begin : g_div
        logic [CW-1:0] dsh;
        logic          take;

        assign dsh  = CW'(d_reg[s]) << (DW-s);
        assign take = (CW'(rem_reg[s]) >= dsh);

        always_ff @(posedge clk)
        begin
            if (load[s+1])
            begin
                rem_reg[s+1]  <= take ? NW'(CW'(rem_reg[s]) - dsh) : rem_reg[s];
                q_reg[s+1]    <= q_reg[s] | ((DW+1)'(take) << (DW-s));
                d_reg[s+1]    <= d_reg[s];
                over_reg[s+1] <= over_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
                zero_reg[s+1] <= zero_reg[s];
            end
        end
    end

    assign quo  = q_reg[NS-1];
    assign over = over_reg[NS-1];
    assign neg  = neg_reg[NS-1];
    assign zero = zero_reg[NS-1];

endmodule

// ----- src/matrix_inverse_3x3_unit.sv -----
// 3x3 fixed-point matrix inverse by adjugate over determinant.
// Uses mi3_pkg, mi3_front and nine mi3_lane instances.
//
// Channels: req_valid/req_ready/req_data carry one matrix (mi3_in_t) per
// transaction; rsp_valid/rsp_ready/rsp_data carry its inverse (mi3_out_t)
// with singular and saturated flags.
// Pipeline: DATA_WIDTH+8 register stages: five front stages (products,
// cofactors, two-part determinant, magnitudes), an overflow check, one
// restoring quotient bit per stage for DATA_WIDTH+1 bits, and the output
// register that merges the nine lanes.
// Throughput: one matrix per cycle while rsp_ready stays high, set by the
// fully pipelined lanes.
// Each stage holds its own valid bit and loads whenever it is empty or its
// successor loads, so bubbles close up while rsp_ready is low; req_ready
// drops only once every stage is full.
// Reset clears all valid bits; data registers are not reset.
module matrix_inverse_3x3_unit
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  mi3_in_t  req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output mi3_out_t rsp_data
);

    localparam int DW   = DATA_WIDTH;
    localparam int LS   = DW+2;
    localparam int NS   = FRONT_STAGES+LS+1;
    localparam int DETW = 3*DW+2;
    localparam int NW   = 2*DW+2*FRAC_BITS+1;
    localparam logic [DW:0] LIM = (DW+1)'(1) << (DW-1);

    logic [NS-1:0]        v_reg;
    logic [NS-1:0]        v_next;
    logic [NS-1:0]        load;
    logic signed [DW-1:0] elem [9];
    logic [DETW-1:0]      dmag;
    logic                 dzero;
    logic [NW-1:0]        nmag [9];
    logic                 nneg [9];
    logic [DW:0]          quo  [9];
    logic                 over [9];
    logic                 neg  [9];
    logic                 zero [9];
    logic [DW-1:0]        r_next [9];
    logic                 sat_next;
    mi3_out_t             out_reg;
    mi3_out_t             out_next;

    assign elem[0] = req_data.a_r0c0;
    assign elem[1] = req_data.a_r0c1;
    assign elem[2] = req_data.a_r0c2;
    assign elem[3] = req_data.a_r1c0;
    assign elem[4] = req_data.a_r1c1;
    assign elem[5] = req_data.a_r1c2;
    assign elem[6] = req_data.a_r2c0;
    assign elem[7] = req_data.a_r2c1;
    assign elem[8] = req_data.a_r2c2;

    always_comb
    begin
        load[NS-1] = !v_reg[NS-1] || rsp_ready;
        for (int i = NS-2; i >= 0; i--)
            load[i] = !v_reg[i] || load[i+1];
        v_next = v_reg;
        for (int i = 0; i < NS; i++)
            if (load[i])
                v_next[i] = (i == 0) ? req_valid : v_reg[(i == 0) ? 0 : i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front
    (
        .clk   (clk),
        .load  (load[FRONT_STAGES-1:0]),
        .elem  (elem),
        .dmag  (dmag),
        .dzero (dzero),
        .nmag  (nmag),
        .nneg  (nneg)
    );

    for (genvar t = 0; t < 9; t++)
    begin : g_lane
        mi3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane
        (
            .clk   (clk),
            .load  (load[FRONT_STAGES+LS-1:FRONT_STAGES]),
            .nmag  (nmag[t]),
            .dmag  (dmag),
            .nneg  (nneg[t]),
            .dzero (dzero),
            .quo   (quo[t]),
            .over  (over[t]),
            .neg   (neg[t]),
            .zero  (zero[t])
        );
    end

    // merge: zero singular or zero results, sign, clip and collect the saturation flag across lanes
    always_comb
    begin
        sat_next = 1'b0;
        for (int t = 0; t < 9; t++)
        begin
            if (zero[t] || (quo[t] == '0 && !over[t]))
                r_next[t] = '0;
            else if (!neg[t])
            begin
                if (over[t] || quo[t] >= LIM)
                begin
                    r_next[t] = DW'(LIM - (DW+1)'(1));
                    sat_next  = 1'b1;
                end
                else
                    r_next[t] = quo[t][DW-1:0];
            end
            else
            begin
                if (over[t] || quo[t] > LIM)
                begin
                    r_next[t] = LIM[DW-1:0];
                    sat_next  = 1'b1;
                end
                else
                    r_next[t] = DW'(-quo[t]);
            end
        end
        out_next.inv_r0c0  = r_next[0];
        out_next.inv_r0c1  = r_next[1];
        out_next.inv_r0c2  = r_next[2];
        out_next.inv_r1c0  = r_next[3];
        out_next.inv_r1c1  = r_next[4];
        out_next.inv_r1c2  = r_next[5];
        out_next.inv_r2c0  = r_next[6];
        out_next.inv_r2c1  = r_next[7];
        out_next.inv_r2c2  = r_next[8];
        out_next.singular  = zero[0];
        out_next.saturated = sat_next;
    end

    always_ff @(posedge clk)
    begin
        if (load[NS-1])
            out_reg <= out_next;
    end

    assign req_ready = load[0];
    assign rsp_valid = v_reg[NS-1];
    assign rsp_data  = out_reg;

endmodule
